### src/knck_pkg.sv
// Shared types and constants of the k-nearest candidate keeper.
`default_nettype none

package knck_pkg;

  localparam int WANT_W      = 7;
  localparam int COUNT_OUT_W = 7;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 3;

  localparam logic [WANT_W-1:0]     WANTED_RST = 7'd50;
  localparam logic [CFG_DATA_W-1:0] RADIUS_RST = 32'hFFFF_FFFF;

  localparam logic REG_WANTED = 1'b0;
  localparam logic REG_RADIUS = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_CLEAR,
    S_DRAIN
  } state_t;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic clear;
    logic shift;
    logic emit_item;
    logic emit_empty;
    logic emit_entry;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic hold_eoq;
    logic count_zero;
    logic aligned;
    logic last_entry;
  } status_t;

  typedef struct packed {
    logic                  wr_wanted;
    logic                  wr_radius;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

endpackage

`default_nettype wire

### src/knck_ctrl.sv
// Sequencer of the keeper: input capture, insert, clear and drain steps.
`default_nettype none

module knck_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire knck_pkg::status_t sts,
  output knck_pkg::cmd_t        cmd
);

  knck_pkg::state_t state_r;
  knck_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= knck_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      knck_pkg::S_IDLE: begin
        if (in_tvalid) state_nxt = knck_pkg::S_EXEC;
      end
      knck_pkg::S_EXEC: begin
        if (sts.hold_eoq) begin
          state_nxt = knck_pkg::S_CLEAR;
        end else if (sts.out_free) begin
          state_nxt = knck_pkg::S_IDLE;
        end
      end
      knck_pkg::S_CLEAR: begin
        if (!sts.count_zero) begin
          state_nxt = knck_pkg::S_DRAIN;
        end else if (sts.out_free) begin
          state_nxt = knck_pkg::S_IDLE;
        end
      end
      knck_pkg::S_DRAIN: begin
        if (sts.aligned && sts.out_free && sts.last_entry) state_nxt = knck_pkg::S_IDLE;
      end
      default: state_nxt = knck_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      knck_pkg::S_IDLE: begin
        in_tready   = 1'b1;
        cmd.load_in = in_tvalid;
      end
      knck_pkg::S_EXEC: begin
        if (sts.hold_eoq) begin
          cmd.exec = 1'b1;
        end else if (sts.out_free) begin
          cmd.exec      = 1'b1;
          cmd.emit_item = 1'b1;
        end
      end
      knck_pkg::S_CLEAR: begin
        if (!sts.count_zero) begin
          cmd.clear = 1'b1;
        end else if (sts.out_free) begin
          cmd.clear      = 1'b1;
          cmd.emit_empty = 1'b1;
        end
      end
      knck_pkg::S_DRAIN: begin
        if (!sts.aligned) begin
          cmd.shift = 1'b1;
        end else if (sts.out_free) begin
          cmd.shift      = 1'b1;
          cmd.emit_entry = 1'b1;
        end
      end
      default: begin
        cmd       = '0;
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

### src/knck_datapath.sv
// Sorted compare-and-shift cells, cutoff, configuration and result register.
`default_nettype none

module knck_datapath #(
  parameter int MAX_KEPT  = 64,
  parameter int ID_BITS   = 24,
  parameter int DIST_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire knck_pkg::cmd_t                cmd,
  output knck_pkg::status_t                  sts,
  input  wire knck_pkg::cfg_wr_t             cfg_wr,
  output logic [knck_pkg::WANT_W-1:0]        wanted,
  output logic [DIST_BITS-1:0]               radius,
  input  wire logic                          in_has,
  input  wire logic [ID_BITS-1:0]            in_id,
  input  wire logic [DIST_BITS-1:0]          in_dist,
  input  wire logic                          in_eoq,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic                               out_accepted,
  output logic [DIST_BITS-1:0]               out_cutoff,
  output logic [knck_pkg::COUNT_OUT_W-1:0]   out_count,
  output logic                               out_entry_valid,
  output logic [ID_BITS-1:0]                 out_entry_id,
  output logic [DIST_BITS-1:0]               out_entry_dist,
  output logic                               out_last
);

  localparam int IDX_W   = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int COUNT_W = $clog2(MAX_KEPT + 1);
  localparam int CMP_W   = (COUNT_W > knck_pkg::WANT_W) ? COUNT_W : knck_pkg::WANT_W;

  logic [knck_pkg::WANT_W-1:0] wanted_r;
  logic [DIST_BITS-1:0]        radius_r;
  logic [DIST_BITS-1:0]        cutoff_r;
  logic [DIST_BITS-1:0]        cutoff_nxt;
  logic [COUNT_W-1:0]          count_r;
  logic [COUNT_W-1:0]          count_nxt;
  logic [IDX_W-1:0]            pos_r;
  logic [COUNT_W-1:0]          rem_r;
  logic                        acc_r;

  logic                        hold_has_r;
  logic [ID_BITS-1:0]          hold_id_r;
  logic [DIST_BITS-1:0]        hold_dist_r;
  logic                        hold_eoq_r;

  logic [DIST_BITS-1:0]        dist_r   [MAX_KEPT];
  logic [ID_BITS-1:0]          id_r     [MAX_KEPT];
  logic [DIST_BITS-1:0]        dist_nxt [MAX_KEPT];
  logic [ID_BITS-1:0]          id_nxt   [MAX_KEPT];
  logic [MAX_KEPT-1:0]         live;
  logic [MAX_KEPT-1:0]         above;

  logic                        out_valid_r;
  logic                        out_acc_r;
  logic [DIST_BITS-1:0]        out_cut_r;
  logic [knck_pkg::COUNT_OUT_W-1:0] out_cnt_r;
  logic                        out_ev_r;
  logic [ID_BITS-1:0]          out_id_r;
  logic [DIST_BITS-1:0]        out_dist_r;
  logic                        out_last_r;

  logic [CMP_W-1:0]            k_eff;
  logic                        full;
  logic                        reach;
  logic                        take;
  logic                        ins;
  logic                        out_free;
  logic                        emit;

  always_comb begin
    priority if (wanted_r == '0) begin
      k_eff = CMP_W'(1);
    end else if (CMP_W'(wanted_r) > CMP_W'(MAX_KEPT)) begin
      k_eff = CMP_W'(MAX_KEPT);
    end else begin
      k_eff = CMP_W'(wanted_r);
    end
  end

  assign full  = CMP_W'(count_r) >= k_eff;
  assign reach = (CMP_W'(count_r) + CMP_W'(1)) >= k_eff;
  assign take  = hold_has_r && (hold_dist_r < cutoff_r);
  assign ins   = cmd.exec && take;

  for (genvar i = 0; i < MAX_KEPT; i++) begin : g_cmp
    assign live[i]  = COUNT_W'(i) < count_r;
    assign above[i] = live[i] && ((dist_r[i] > hold_dist_r) ||
                                  ((dist_r[i] == hold_dist_r) && (id_r[i] > hold_id_r)));
  end

  for (genvar i = 0; i < MAX_KEPT; i++) begin : g_cell
    logic                 up_ab;
    logic [DIST_BITS-1:0] up_dist;
    logic [ID_BITS-1:0]   up_id;
    logic                 dn_ab;
    logic [DIST_BITS-1:0] dn_dist;
    logic [ID_BITS-1:0]   dn_id;
    logic                 rp_here;
    logic [DIST_BITS-1:0] nf_dist;
    logic [ID_BITS-1:0]   nf_id;
    logic [DIST_BITS-1:0] rp_dist;
    logic [ID_BITS-1:0]   rp_id;

    if (i == 0) begin : g_first
      assign up_ab   = 1'b1;
      assign up_dist = dist_r[i];
      assign up_id   = id_r[i];
      assign rp_here = 1'b1;
    end else begin : g_up
      assign up_ab   = above[i-1];
      assign up_dist = dist_r[i-1];
      assign up_id   = id_r[i-1];
      assign rp_here = above[i];
    end

    if (i == MAX_KEPT - 1) begin : g_last
      assign dn_ab   = 1'b0;
      assign dn_dist = dist_r[i];
      assign dn_id   = id_r[i];
    end else begin : g_dn
      assign dn_ab   = above[i+1];
      assign dn_dist = dist_r[i+1];
      assign dn_id   = id_r[i+1];
    end

    assign nf_dist = above[i] ? dist_r[i] : (up_ab ? hold_dist_r : up_dist);
    assign nf_id   = above[i] ? id_r[i]   : (up_ab ? hold_id_r   : up_id);
    assign rp_dist = dn_ab ? dn_dist : (rp_here ? hold_dist_r : dist_r[i]);
    assign rp_id   = dn_ab ? dn_id   : (rp_here ? hold_id_r   : id_r[i]);

    assign dist_nxt[i] = (ins && !full && (COUNT_W'(i) <= count_r)) ? nf_dist :
                         (ins && full && live[i])                   ? rp_dist :
                         cmd.shift                                  ? up_dist : dist_r[i];
    assign id_nxt[i]   = (ins && !full && (COUNT_W'(i) <= count_r)) ? nf_id :
                         (ins && full && live[i])                   ? rp_id :
                         cmd.shift                                  ? up_id : id_r[i];
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_KEPT; i++) begin
      dist_r[i] <= dist_nxt[i];
      id_r[i]   <= id_nxt[i];
    end
  end

  always_comb begin
    count_nxt  = count_r;
    cutoff_nxt = cutoff_r;
    priority if (cmd.clear) begin
      count_nxt  = '0;
      cutoff_nxt = radius_r;
    end else if (ins) begin
      if (!full) count_nxt = count_r + COUNT_W'(1);
      if (full || reach) cutoff_nxt = dist_nxt[0];
    end else if (cfg_wr.wr_radius && (count_r == '0)) begin
      cutoff_nxt = DIST_BITS'(cfg_wr.data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wanted_r <= knck_pkg::WANTED_RST;
      radius_r <= DIST_BITS'(knck_pkg::RADIUS_RST);
      cutoff_r <= DIST_BITS'(knck_pkg::RADIUS_RST);
      count_r  <= '0;
      pos_r    <= '0;
      rem_r    <= '0;
      acc_r    <= 1'b0;
    end else begin
      if (cfg_wr.wr_wanted) wanted_r <= knck_pkg::WANT_W'(cfg_wr.data);
      if (cfg_wr.wr_radius) radius_r <= DIST_BITS'(cfg_wr.data);
      cutoff_r <= cutoff_nxt;
      count_r  <= count_nxt;
      if (cmd.exec) acc_r <= take;
      if (cmd.clear) begin
        pos_r <= IDX_W'(count_r - COUNT_W'(1));
        rem_r <= count_r;
      end else begin
        if (cmd.shift && !cmd.emit_entry) pos_r <= pos_r + IDX_W'(1);
        if (cmd.emit_entry) rem_r <= rem_r - COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      hold_has_r  <= in_has;
      hold_id_r   <= in_id;
      hold_dist_r <= in_dist;
      hold_eoq_r  <= in_eoq;
    end
  end

  assign out_free = !out_valid_r || out_ready;
  assign emit     = cmd.emit_item || cmd.emit_empty || cmd.emit_entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    priority if (cmd.emit_item) begin
      out_acc_r  <= take;
      out_cut_r  <= cutoff_nxt;
      out_cnt_r  <= knck_pkg::COUNT_OUT_W'(count_nxt);
      out_ev_r   <= 1'b0;
      out_id_r   <= '0;
      out_dist_r <= '0;
      out_last_r <= 1'b1;
    end else if (cmd.emit_empty) begin
      out_acc_r  <= acc_r;
      out_cut_r  <= radius_r;
      out_cnt_r  <= '0;
      out_ev_r   <= 1'b0;
      out_id_r   <= '0;
      out_dist_r <= '0;
      out_last_r <= 1'b1;
    end else if (cmd.emit_entry) begin
      out_acc_r  <= acc_r;
      out_cut_r  <= radius_r;
      out_cnt_r  <= '0;
      out_ev_r   <= 1'b1;
      out_id_r   <= id_r[MAX_KEPT-1];
      out_dist_r <= dist_r[MAX_KEPT-1];
      out_last_r <= (rem_r == COUNT_W'(1));
    end else begin
      out_acc_r  <= out_acc_r;
    end
  end

  assign sts.out_free   = out_free;
  assign sts.hold_eoq   = hold_eoq_r;
  assign sts.count_zero = (count_r == '0);
  assign sts.aligned    = (pos_r == IDX_W'(MAX_KEPT - 1));
  assign sts.last_entry = (rem_r == COUNT_W'(1));

  assign wanted          = wanted_r;
  assign radius          = radius_r;
  assign out_valid       = out_valid_r;
  assign out_accepted    = out_acc_r;
  assign out_cutoff      = out_cut_r;
  assign out_count       = out_cnt_r;
  assign out_entry_valid = out_ev_r;
  assign out_entry_id    = out_id_r;
  assign out_entry_dist  = out_dist_r;
  assign out_last        = out_last_r;

endmodule

`default_nettype wire

### src/k_nearest_candidate_keeper.sv
// Top level of the k-nearest candidate keeper: stream ports, register port, assembly.
// An accepted beat is captured in the hold registers; its result beat is registered
// once the output is free. A new beat is taken only after that result is registered.
// End of query: clear, MAX_KEPT - n alignment shifts and n entry beats (n kept).
// Each entry pops from the nearest end of the row, one a cycle while output is free.
// Reset: kept count 0, cutoff and radius all ones, wanted count 50; cells unwritten.
`default_nettype none

module k_nearest_candidate_keeper #(
  parameter int MAX_KEPT  = 64,
  parameter int ID_BITS   = 24,
  parameter int DIST_BITS = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  // tdata: candidate_id, distance_sq (lowest first); tuser: has_candidate
  input  wire logic                                         in_tvalid,
  output logic                                              in_tready,
  input  wire logic [((ID_BITS + DIST_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  input  wire logic                                         in_tuser,
  input  wire logic                                         in_tlast,
  // tdata: cutoff_sq, kept_count, entry_id, entry_distance (lowest first)
  // tuser: accepted, entry_valid (lowest first)
  output logic                                              out_tvalid,
  input  wire logic                                         out_tready,
  output logic [((2 * DIST_BITS + ID_BITS + knck_pkg::COUNT_OUT_W + 7) / 8) * 8 - 1:0]
                                                            out_tdata,
  output logic [1:0]                                        out_tuser,
  output logic                                              out_tlast,
  input  wire logic                                         cfg_psel,
  input  wire logic                                         cfg_penable,
  input  wire logic                                         cfg_pwrite,
  input  wire logic [knck_pkg::CFG_ADDR_W-1:0]              cfg_paddr,
  input  wire logic [knck_pkg::CFG_DATA_W-1:0]              cfg_pwdata,
  output logic [knck_pkg::CFG_DATA_W-1:0]                   cfg_prdata,
  output logic                                              cfg_pready
);

  localparam int OUT_RAW_W  = 2 * DIST_BITS + ID_BITS + knck_pkg::COUNT_OUT_W;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;
  localparam int CNT_LSB    = DIST_BITS;

  knck_pkg::cmd_t    cmd;
  knck_pkg::status_t sts;
  knck_pkg::cfg_wr_t cfg_wr;

  logic [knck_pkg::WANT_W-1:0]      wanted;
  logic [DIST_BITS-1:0]             radius;
  logic                             o_acc;
  logic [DIST_BITS-1:0]             o_cut;
  logic [knck_pkg::COUNT_OUT_W-1:0] o_cnt;
  logic                             o_ev;
  logic [ID_BITS-1:0]               o_id;
  logic [DIST_BITS-1:0]             o_dist;
  logic                             wr_beat;

  assign cfg_pready = 1'b1;
  assign wr_beat    = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  assign cfg_wr.wr_wanted = wr_beat && (cfg_paddr[2] == knck_pkg::REG_WANTED);
  assign cfg_wr.wr_radius = wr_beat && (cfg_paddr[2] == knck_pkg::REG_RADIUS);
  assign cfg_wr.data      = cfg_pwdata;

  assign cfg_prdata = (cfg_paddr[2] == knck_pkg::REG_RADIUS) ?
                      knck_pkg::CFG_DATA_W'(radius) : knck_pkg::CFG_DATA_W'(wanted);

  knck_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  knck_datapath #(
    .MAX_KEPT  (MAX_KEPT),
    .ID_BITS   (ID_BITS),
    .DIST_BITS (DIST_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_wr          (cfg_wr),
    .wanted          (wanted),
    .radius          (radius),
    .in_has          (in_tuser),
    .in_id           (in_tdata[ID_BITS-1:0]),
    .in_dist         (in_tdata[ID_BITS +: DIST_BITS]),
    .in_eoq          (in_tlast),
    .out_ready       (out_tready),
    .out_valid       (out_tvalid),
    .out_accepted    (o_acc),
    .out_cutoff      (o_cut),
    .out_count       (o_cnt),
    .out_entry_valid (o_ev),
    .out_entry_id    (o_id),
    .out_entry_dist  (o_dist),
    .out_last        (out_tlast)
  );

  assign out_tdata = OUT_DATA_W'({o_dist, o_id, o_cnt, o_cut});
  assign out_tuser = {o_ev, o_acc};

  a_drain_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> (out_tdata[CNT_LSB +: knck_pkg::COUNT_OUT_W] == '0))
    else $error("drained entry beat carries a nonzero kept count");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second input beat taken while an item is in work");

  a_mid_run_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> out_tuser[1])
    else $error("non-final result beat without a drained entry");

endmodule

`default_nettype wire
